@@ sv/push_switch_qualifier_top_assert.svh @@
// assertion macros for the push switch qualifier
// used by push_switch_qualifier_top; needs clk and arst_n in scope
`ifndef PUSH_SWITCH_QUALIFIER_TOP_ASSERT_SVH
`define PUSH_SWITCH_QUALIFIER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PSQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/psq_pkg.sv @@
// package for the push switch qualifier: operation codes, register indexes
// and configuration reset values; no dependencies
package psq_pkg;

	// request operation codes
	typedef enum logic [1:0] {
		OP_POLL     = 2'd0,
		OP_SUPPRESS = 2'd1,
		OP_RESYNC   = 2'd2
	} op_t;

	// configuration register indexes
	localparam logic [1:0] REG_RELEASE_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_GUARD            = 2'd1;
	localparam logic [1:0] REG_LONG_PRESS       = 2'd2;

	localparam int CFG_W  = 16;
	localparam int TIME_W = 32;

	// configuration reset values in ms
	localparam logic [CFG_W-1:0] RELEASE_DEBOUNCE_RST = 16'd25;
	localparam logic [CFG_W-1:0] GUARD_RST            = 16'd200;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST       = 16'd750;

	// result of one request
	typedef struct packed {
		logic select_press;
		logic long_press;
		logic a_press;
		logic b_press;
	} result_t;

endpackage

@@ sv/push_switch_qualifier_top.sv @@
// push switch qualifier top level; uses psq_pkg and the assertion header
// path: request accept to result valid passes the input register and then the result register
// throughput: one request per cycle while out_ready does not stall the result register; the switch
//   state is read and updated by compare and 32-bit subtract logic between the input and result registers
// reset: arst_n clears both stages, loads switch state to released/armed and the
//   configuration registers to 25, 200 and 750 ms
`include "push_switch_qualifier_top_assert.svh"

module push_switch_qualifier_top (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] now_ms,
	input  logic        select_level,
	input  logic        a_level,
	input  logic        b_level,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        select_press,
	output logic        long_press,
	output logic        a_press,
	output logic        b_press,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int TW = psq_pkg::TIME_W;
	localparam int CW = psq_pkg::CFG_W;

	// configuration registers
	logic [CW-1:0] release_debounce_q, guard_q, long_press_q;

	// input stage
	logic          valid_s1;
	psq_pkg::op_t  op_s1;
	logic [TW-1:0] now_s1;
	logic          sel_s1, a_s1, b_s1;

	// switch state
	logic          prev_select_q, prev_a_q, prev_b_q;
	logic          armed_q, suppressed_q;
	logic [TW-1:0] release_time_q, suppress_time_q, hold_start_q;
	logic          hold_timing_q, long_reported_q;

	// next state
	logic          prev_select_d, prev_a_d, prev_b_d;
	logic          armed_d, suppressed_d;
	logic [TW-1:0] release_time_d, suppress_time_d, hold_start_d;
	logic          hold_timing_d, long_reported_d;

	// result stage
	logic              out_valid_q;
	psq_pkg::result_t  result_q, result_d;

	logic adv;

	// handshakes
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_debounce_q <= psq_pkg::RELEASE_DEBOUNCE_RST;
			guard_q            <= psq_pkg::GUARD_RST;
			long_press_q       <= psq_pkg::LONG_PRESS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				psq_pkg::REG_RELEASE_DEBOUNCE: release_debounce_q <= cfg_data;
				psq_pkg::REG_GUARD:            guard_q            <= cfg_data;
				psq_pkg::REG_LONG_PRESS:       long_press_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= psq_pkg::op_t'(operation);
			now_s1 <= now_ms;
			sel_s1 <= select_level;
			a_s1   <= a_level;
			b_s1   <= b_level;
		end
	end

	// per-request logic: long press timer, select press logic, plain edges
	always_comb begin
		logic [TW-1:0] hold_base;
		logic [TW-1:0] rel_time;
		logic          lr_cur;
		logic          armed_pre;
		logic          hit;

		prev_select_d   = prev_select_q;
		prev_a_d        = prev_a_q;
		prev_b_d        = prev_b_q;
		armed_d         = armed_q;
		suppressed_d    = suppressed_q;
		release_time_d  = release_time_q;
		suppress_time_d = suppress_time_q;
		hold_start_d    = hold_start_q;
		hold_timing_d   = hold_timing_q;
		long_reported_d = long_reported_q;
		result_d        = '0;

		hold_base = hold_timing_q ? hold_start_q : now_s1;
		lr_cur    = hold_timing_q && long_reported_q;
		rel_time  = (sel_s1 && !prev_select_q) ? now_s1 : release_time_q;
		armed_pre = armed_q ||
			(sel_s1 && ((now_s1 - rel_time) >= {{(TW-CW){1'b0}}, release_debounce_q}));
		hit       = !sel_s1 && prev_select_q && armed_pre;

		case (op_s1)
			psq_pkg::OP_POLL: begin
				// long press timer, sees suppression as it was before this poll
				if (suppressed_q || sel_s1) begin
					hold_timing_d   = 1'b0;
					long_reported_d = 1'b0;
				end else begin
					hold_start_d    = hold_base;
					hold_timing_d   = 1'b1;
					long_reported_d = lr_cur;
					if (!lr_cur &&
						((now_s1 - hold_base) >= {{(TW-CW){1'b0}}, long_press_q})) begin
						long_reported_d     = 1'b1;
						result_d.long_press = 1'b1;
					end
				end
				// select press qualification
				release_time_d = rel_time;
				prev_select_d  = sel_s1;
				if (suppressed_q) begin
					armed_d = armed_pre;
					if (sel_s1 && armed_pre &&
						((now_s1 - suppress_time_q) >= {{(TW-CW){1'b0}}, guard_q})) begin
						suppressed_d = 1'b0;
					end
				end else begin
					armed_d               = armed_pre && !hit;
					result_d.select_press = hit;
				end
				// buttons a and b
				result_d.a_press = !a_s1 && prev_a_q;
				result_d.b_press = !b_s1 && prev_b_q;
				prev_a_d         = a_s1;
				prev_b_d         = b_s1;
			end
			psq_pkg::OP_SUPPRESS: begin
				prev_select_d   = sel_s1;
				armed_d         = 1'b0;
				suppressed_d    = 1'b1;
				suppress_time_d = now_s1;
				if (sel_s1) begin
					release_time_d = now_s1;
				end
			end
			psq_pkg::OP_RESYNC: begin
				prev_select_d   = sel_s1;
				prev_a_d        = a_s1;
				prev_b_d        = b_s1;
				armed_d         = sel_s1;
				release_time_d  = now_s1;
				suppressed_d    = 1'b0;
				suppress_time_d = '0;
			end
			default: ;
		endcase
	end

	// switch state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_select_q   <= 1'b1;
			prev_a_q        <= 1'b1;
			prev_b_q        <= 1'b1;
			armed_q         <= 1'b1;
			suppressed_q    <= 1'b0;
			release_time_q  <= '0;
			suppress_time_q <= '0;
			hold_start_q    <= '0;
			hold_timing_q   <= 1'b0;
			long_reported_q <= 1'b0;
		end else if (adv) begin
			prev_select_q   <= prev_select_d;
			prev_a_q        <= prev_a_d;
			prev_b_q        <= prev_b_d;
			armed_q         <= armed_d;
			suppressed_q    <= suppressed_d;
			release_time_q  <= release_time_d;
			suppress_time_q <= suppress_time_d;
			hold_start_q    <= hold_start_d;
			hold_timing_q   <= hold_timing_d;
			long_reported_q <= long_reported_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= result_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign select_press = result_q.select_press;
	assign long_press   = result_q.long_press;
	assign a_press      = result_q.a_press;
	assign b_press      = result_q.b_press;

	// checks
	`PSQ_ASSERT_NEXT(a_nonpoll_quiet, adv && (op_s1 != psq_pkg::OP_POLL),
		!select_press && !long_press && !a_press && !b_press,
		"non-poll request produced a press")
	`PSQ_ASSERT_NOW(a_press_disarms, out_valid_q && result_q.select_press, !armed_q,
		"select press left the switch armed")
	`PSQ_ASSERT_NEXT(a_suppress_state, adv && (op_s1 == psq_pkg::OP_SUPPRESS),
		suppressed_q && !armed_q, "suppress did not disarm")
	`PSQ_ASSERT_NOW(a_long_marked, out_valid_q && result_q.long_press,
		long_reported_q && hold_timing_q, "long press not recorded in timer state")
	`PSQ_ASSERT_NOW(a_stall_blocks, valid_s1 && out_valid_q && !out_ready, !in_ready,
		"input taken while both stages are full")

endmodule
